FILE: hw/rtl/three_digit_led_display_refresh_macros.svh
// Assertion helpers shared by the display refresh block.
`ifndef THREE_DIGIT_LED_DISPLAY_REFRESH_MACROS_SVH
`define THREE_DIGIT_LED_DISPLAY_REFRESH_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define TDLDR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define TDLDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tdldr_pkg.sv
package tdldr_pkg;

    // Digit count default and fixed segment word width
    localparam int DIGIT_COUNT_DEF = 3;
    localparam int SEGMENT_BITS    = 8;
    localparam int VALUE_BITS      = 16;

    // Segment constants (active low)
    localparam logic [7:0] POINT_BIT  = 8'h80;
    localparam logic [7:0] BLANK_CODE = 8'h7F;

    // Divide by ten: q = (v * 52429) >> 19, exact for 16-bit v
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    // Step codes within one digit (20 images)
    localparam logic [4:0] STEP_STORE_HI = 5'd16;
    localparam logic [4:0] STEP_ANODE_ON = 5'd18;
    localparam logic [4:0] STEP_LAST     = 5'd19;

    // Anode codes
    localparam logic [1:0] ANODE_OFF      = 2'd0;
    localparam logic [1:0] ANODE_HUNDREDS = 2'd1;
    localparam logic [1:0] ANODE_TENS     = 2'd2;
    localparam logic [1:0] ANODE_ONES     = 2'd3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // One pin image, last field in the lowest bit
    typedef struct packed {
        logic [1:0] anode_select;
        logic       store_clock;
        logic       shift_clock;
        logic       serial_data;
    } image_t;

    // Decimal digit to active-low segment code, point bit low
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        begin
            unique case (digit)
                4'd0:    code = 8'h01;
                4'd1:    code = 8'h79;
                4'd2:    code = 8'h12;
                4'd3:    code = 8'h30;
                4'd4:    code = 8'h68;
                4'd5:    code = 8'h24;
                4'd6:    code = 8'h04;
                4'd7:    code = 8'h71;
                4'd8:    code = 8'h00;
                4'd9:    code = 8'h20;
                default: code = BLANK_CODE;
            endcase
            return code;
        end
    endfunction

    // Digit position to anode code; positions past hundreds have no anode
    function automatic logic [1:0] anode_code(input logic [3:0] pos);
        logic [1:0] code;
        begin
            unique case (pos)
                4'd0:    code = ANODE_ONES;
                4'd1:    code = ANODE_TENS;
                4'd2:    code = ANODE_HUNDREDS;
                default: code = ANODE_OFF;
            endcase
            return code;
        end
    endfunction

endpackage

FILE: hw/rtl/tdldr_front.sv
module tdldr_front
    import tdldr_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [VALUE_BITS-1:0]             in_value,
    input  logic                              in_red,
    input  logic                              in_green,
    input  queue_stat_t                       q_stat,
    output logic                              q_push,
    output logic [DIGIT_COUNT*SEGMENT_BITS-1:0] q_data
);

    localparam int DIGIT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int CODE_W  = DIGIT_COUNT * SEGMENT_BITS;

    logic                  busy_reg, busy_next;
    logic [DIGIT_W-1:0]    digit_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  red_reg;
    logic                  green_reg;
    logic [CODE_W-1:0]     acc_reg;

    logic [32:0]           prod;
    logic [VALUE_BITS-1:0] quot;
    logic [VALUE_BITS-1:0] quot_x10;
    logic [3:0]            rem;
    logic                  led_on;
    logic [7:0]            dcode;
    logic [CODE_W-1:0]     acc_now;
    logic                  last_digit;
    logic                  step_ok;
    logic                  accept;

    // Split off one decimal digit per cycle, holding the last one while the queue is full
    always_comb
    begin
        prod     = 33'(val_reg) * 33'(DIV10_MUL);
        quot     = VALUE_BITS'(prod >> DIV10_SHIFT);
        quot_x10 = (quot << 3) + (quot << 1);
        rem      = 4'(val_reg - quot_x10);
        led_on   = (digit_reg == '0) ? red_reg : green_reg;
        dcode    = seg_code(rem) | (led_on ? 8'h00 : POINT_BIT);
        acc_now  = acc_reg;
        acc_now[digit_reg*SEGMENT_BITS +: SEGMENT_BITS] = dcode;
    end

    // Push the finished code word, take the next request in the same cycle
    always_comb
    begin
        last_digit = (digit_reg == DIGIT_W'(DIGIT_COUNT - 1));
        q_push     = busy_reg && last_digit && !q_stat.full;
        step_ok    = busy_reg && !last_digit;
        in_ready   = !busy_reg || q_push;
        accept     = in_valid && in_ready;
        q_data     = acc_now;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (q_push)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            busy_next = busy_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            digit_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (accept)
            begin
                digit_reg <= '0;
            end
            else if (step_ok)
            begin
                digit_reg <= digit_reg + 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg   <= in_value;
            red_reg   <= in_red;
            green_reg <= in_green;
        end
        else if (step_ok)
        begin
            val_reg <= quot;
            acc_reg <= acc_now;
        end
    end

endmodule

FILE: hw/rtl/tdldr_queue.sv
module tdldr_queue
    import tdldr_pkg::*;
#(
    parameter int WIDTH = DIGIT_COUNT_DEF * SEGMENT_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output queue_stat_t      stat
);

    logic [WIDTH-1:0]       mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;

    // Status and head entry
    always_comb
    begin
        stat.full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
        stat.empty = (count_reg == '0);
        pop_data   = mem_reg[rd_ptr_reg];
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/tdldr_back.sv
module tdldr_back
    import tdldr_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  queue_stat_t                         q_stat,
    input  logic [DIGIT_COUNT*SEGMENT_BITS-1:0] q_data,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output image_t                              out_image,
    output logic                                out_last
);

    localparam int DIGIT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int CODE_W  = DIGIT_COUNT * SEGMENT_BITS;

    logic               busy_reg;
    logic [DIGIT_W-1:0] digit_reg;
    logic [4:0]         step_reg;
    logic [CODE_W-1:0]  ent_reg;
    logic               valid_reg;
    image_t             image_reg;
    logic               last_reg;

    logic [7:0]         cur_code;
    image_t             cur_image;
    logic               last_img;
    logic               adv;

    // Build the pin image for the current step
    always_comb
    begin
        cur_code = ent_reg[SEGMENT_BITS-1:0];
        last_img = (digit_reg == DIGIT_W'(DIGIT_COUNT - 1)) && (step_reg == STEP_LAST);
        if (step_reg < STEP_STORE_HI)
        begin
            cur_image.serial_data = cur_code[step_reg[3:1]];
            cur_image.shift_clock = !step_reg[0];
        end
        else
        begin
            cur_image.serial_data = cur_code[SEGMENT_BITS-1];
            cur_image.shift_clock = 1'b0;
        end
        cur_image.store_clock  = (step_reg == STEP_STORE_HI);
        cur_image.anode_select = (step_reg == STEP_ANODE_ON)
                                 ? anode_code(4'(digit_reg)) : ANODE_OFF;
        adv   = busy_reg && (!valid_reg || out_ready);
        q_pop = !q_stat.empty && (!busy_reg || (adv && last_img));
    end

    // Sequencer control and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            digit_reg <= '0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg  <= 1'b1;
                digit_reg <= '0;
                step_reg  <= '0;
            end
            else if (adv && last_img)
            begin
                busy_reg <= 1'b0;
            end
            else if (adv)
            begin
                if (step_reg == STEP_LAST)
                begin
                    step_reg  <= '0;
                    digit_reg <= digit_reg + 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end

            if (adv)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Code words and output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ent_reg <= q_data;
        end
        else if (adv && step_reg == STEP_LAST)
        begin
            ent_reg <= ent_reg >> SEGMENT_BITS;
        end
        if (adv)
        begin
            image_reg <= cur_image;
            last_reg  <= last_img;
        end
    end

    assign out_valid = valid_reg;
    assign out_image = image_reg;
    assign out_last  = last_reg;

endmodule

FILE: hw/rtl/three_digit_led_display_refresh.sv
// Channel | Direction | Payload
// s_axis  | in        | tdata[15:0] display_value, [16] red_led_on, [17] green_led_on
// m_axis  | out       | tdata[0] serial_data, [1] shift_clock, [2] store_clock,
//         |           | [4:3] anode_select; tlast last_step
//
// The back-end step sequencer gives 20 * DIGIT_COUNT pin images per request, one per
// cycle while m_tready allows; a queued request follows the last with no gap.
// The front end splits off one digit per cycle, the last held while the queue is full,
// into a two-entry code queue, so it takes the next request while images stream.
// The first image follows the digit split, the code queue and the output image register.
// Reset clears all control; m_tready low holds the image in its register.
`include "three_digit_led_display_refresh_macros.svh"

module three_digit_led_display_refresh
    import tdldr_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] display_value, [16] red_led_on,
                                        // [17] green_led_on, [23:18] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] serial_data, [1] shift_clock,
                                        // [2] store_clock, [4:3] anode_select,
                                        // [7:5] zero
    output logic        m_axis_tlast
);

    localparam int CODE_W = DIGIT_COUNT * SEGMENT_BITS;

    queue_stat_t       q_stat;
    logic              q_push;
    logic              q_pop;
    logic [CODE_W-1:0] q_wr_data;
    logic [CODE_W-1:0] q_rd_data;
    image_t            image;

    // Digit split
    tdldr_front #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_value (s_axis_tdata[15:0]),
        .in_red   (s_axis_tdata[16]),
        .in_green (s_axis_tdata[17]),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    // Code word queue
    tdldr_queue #(
        .WIDTH (CODE_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wr_data),
        .pop       (q_pop),
        .pop_data  (q_rd_data),
        .stat      (q_stat)
    );

    // Pin image sequencer
    tdldr_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_image (image),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, image};

    `TDLDR_ASSERT_NOW(a_clocks_apart, m_axis_tvalid, !(image.shift_clock && image.store_clock), "shift and store clocks both high")
    `TDLDR_ASSERT_NOW(a_anode_quiet, m_axis_tvalid && (image.anode_select != ANODE_OFF), !image.shift_clock && !image.store_clock, "anode on during shift or store")
    `TDLDR_ASSERT_NOW(a_last_off, m_axis_tvalid && m_axis_tlast, image.anode_select == ANODE_OFF, "final image leaves an anode on")
    `TDLDR_ASSERT_NOW(a_queue_push, q_push, !q_stat.full, "push into full queue")
    `TDLDR_ASSERT_NEXT(a_store_low, m_axis_tvalid && m_axis_tready && image.store_clock, !image.store_clock, "store pulse longer than one image")

endmodule
